// ===== sv/pwsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsp_pkg: shared types and constants of the pendulum step planner
// Sequencer states, arithmetic opcodes, scratch slot map, config reset
// values and the step microprogram.
// ----------------------------------------------------------------------------
package pwsp_pkg;

  // arithmetic unit opcodes
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_HALF,
    OP_ALT
  } op_e;

  // step sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH,
    ST_START,
    ST_WAIT,
    ST_OUT_RD,
    ST_OUT_COM,
    ST_OUT_FOOT
  } st_e;

  typedef struct packed {
    logic start;
    op_e  op;
    logic odd;
  } alu_cmd_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_sts_t;

  typedef logic [4:0] slot_t;

  typedef struct packed {
    op_e   op;
    slot_t dst;
    slot_t a;
    slot_t b;
  } instr_t;

  // scratch slot map
  localparam slot_t SL_Z   = 5'd0;
  localparam slot_t SL_ONE = 5'd1;
  localparam slot_t SL_C   = 5'd2;
  localparam slot_t SL_S   = 5'd3;
  localparam slot_t SL_TC  = 5'd4;
  localparam slot_t SL_SX  = 5'd5;
  localparam slot_t SL_SY  = 5'd6;
  localparam slot_t SL_WA  = 5'd7;
  localparam slot_t SL_WB  = 5'd8;
  localparam slot_t SL_PX  = 5'd9;
  localparam slot_t SL_PY  = 5'd10;
  localparam slot_t SL_VX  = 5'd11;
  localparam slot_t SL_VY  = 5'd12;
  localparam slot_t SL_NFX = 5'd13;
  localparam slot_t SL_NFY = 5'd14;
  localparam slot_t SL_PFX = 5'd15;
  localparam slot_t SL_PFY = 5'd16;
  localparam slot_t SL_T0  = 5'd17;
  localparam slot_t SL_T1  = 5'd18;
  localparam slot_t SL_T2  = 5'd19;
  localparam slot_t SL_T3  = 5'd20;
  localparam slot_t SL_T4  = 5'd21;
  localparam slot_t SL_T5  = 5'd22;
  localparam slot_t SL_T6  = 5'd23;
  localparam slot_t SL_T7  = 5'd24;
  localparam slot_t SL_T8  = 5'd25;
  localparam slot_t SL_T9  = 5'd26;
  localparam slot_t SL_T10 = 5'd27;
  localparam slot_t SL_T11 = 5'd28;
  localparam slot_t SL_T12 = 5'd29;
  localparam slot_t SL_T13 = 5'd30;

  localparam int NUM_SLOTS = 32;
  localparam int NUM_CFG   = 7;
  localparam int NUM_INSTR = 70;

  localparam logic [31:0] CFG_RESET [NUM_CFG] = '{
    32'd333364, 32'd326855, 32'd9362, 32'd19661, 32'd13107, 32'd655360, 32'd65536
  };
  localparam logic [31:0] CFG_MASK [NUM_CFG] = '{
    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
    32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff
  };
  localparam logic CFG_SIGNED [NUM_CFG] = '{
    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0
  };

  // one step of the planner as a list of dst = a op b
  function automatic instr_t prog(input logic [6:0] pc);
    instr_t i;
    case (pc)
      // pendulum advance
      7'd0:  i = '{OP_SUB, SL_T0, SL_PX, SL_PFX};
      7'd1:  i = '{OP_SUB, SL_T1, SL_PY, SL_PFY};
      7'd2:  i = '{OP_MUL, SL_T2, SL_T0, SL_C};
      7'd3:  i = '{OP_MUL, SL_T3, SL_TC, SL_VX};
      7'd4:  i = '{OP_MUL, SL_T3, SL_T3, SL_S};
      7'd5:  i = '{OP_ADD, SL_T2, SL_T2, SL_T3};
      7'd6:  i = '{OP_ADD, SL_T2, SL_T2, SL_PFX};
      7'd7:  i = '{OP_MUL, SL_T3, SL_T1, SL_C};
      7'd8:  i = '{OP_MUL, SL_T4, SL_TC, SL_VY};
      7'd9:  i = '{OP_MUL, SL_T4, SL_T4, SL_S};
      7'd10: i = '{OP_ADD, SL_T3, SL_T3, SL_T4};
      7'd11: i = '{OP_ADD, SL_T3, SL_T3, SL_PFY};
      7'd12: i = '{OP_DIV, SL_T4, SL_T0, SL_TC};
      7'd13: i = '{OP_MUL, SL_T4, SL_T4, SL_S};
      7'd14: i = '{OP_MUL, SL_T5, SL_VX, SL_C};
      7'd15: i = '{OP_ADD, SL_T4, SL_T4, SL_T5};
      7'd16: i = '{OP_DIV, SL_T5, SL_T1, SL_TC};
      7'd17: i = '{OP_MUL, SL_T5, SL_T5, SL_S};
      7'd18: i = '{OP_MUL, SL_T6, SL_VY, SL_C};
      7'd19: i = '{OP_ADD, SL_T5, SL_T5, SL_T6};
      // nominal foot and half stride
      7'd20: i = '{OP_ALT, SL_SY, SL_Z, SL_SY};
      7'd21: i = '{OP_ADD, SL_NFX, SL_NFX, SL_SX};
      7'd22: i = '{OP_ADD, SL_NFY, SL_NFY, SL_SY};
      7'd23: i = '{OP_HALF, SL_T0, SL_SX, SL_Z};
      7'd24: i = '{OP_HALF, SL_T1, SL_SY, SL_Z};
      // gains
      7'd25: i = '{OP_SUB, SL_T6, SL_C, SL_ONE};
      7'd26: i = '{OP_MUL, SL_T7, SL_TC, SL_S};
      7'd27: i = '{OP_DIV, SL_T8, SL_T6, SL_T7};
      7'd28: i = '{OP_DIV, SL_T9, SL_S, SL_TC};
      7'd29: i = '{OP_MUL, SL_T10, SL_WA, SL_T6};
      7'd30: i = '{OP_MUL, SL_T10, SL_T10, SL_T6};
      7'd31: i = '{OP_MUL, SL_T11, SL_WB, SL_T9};
      7'd32: i = '{OP_MUL, SL_T11, SL_T11, SL_T9};
      7'd33: i = '{OP_ADD, SL_T10, SL_T10, SL_T11};
      7'd34: i = '{OP_SUB, SL_T11, SL_Z, SL_WA};
      7'd35: i = '{OP_MUL, SL_T11, SL_T11, SL_T6};
      7'd36: i = '{OP_DIV, SL_T11, SL_T11, SL_T10};
      7'd37: i = '{OP_MUL, SL_T12, SL_WB, SL_S};
      7'd38: i = '{OP_MUL, SL_T13, SL_TC, SL_T10};
      7'd39: i = '{OP_DIV, SL_T12, SL_T12, SL_T13};
      // forward placement
      7'd40: i = '{OP_ADD, SL_T13, SL_NFX, SL_T0};
      7'd41: i = '{OP_MUL, SL_T0, SL_T8, SL_T0};
      7'd42: i = '{OP_MUL, SL_T10, SL_C, SL_T2};
      7'd43: i = '{OP_SUB, SL_T13, SL_T13, SL_T10};
      7'd44: i = '{OP_MUL, SL_T10, SL_T7, SL_T4};
      7'd45: i = '{OP_SUB, SL_T13, SL_T13, SL_T10};
      7'd46: i = '{OP_MUL, SL_T10, SL_T9, SL_T2};
      7'd47: i = '{OP_SUB, SL_T0, SL_T0, SL_T10};
      7'd48: i = '{OP_MUL, SL_T10, SL_C, SL_T4};
      7'd49: i = '{OP_SUB, SL_T0, SL_T0, SL_T10};
      7'd50: i = '{OP_MUL, SL_T13, SL_T11, SL_T13};
      7'd51: i = '{OP_MUL, SL_T0, SL_T12, SL_T0};
      7'd52: i = '{OP_SUB, SL_PFX, SL_T13, SL_T0};
      // lateral placement
      7'd53: i = '{OP_ADD, SL_T13, SL_NFY, SL_T1};
      7'd54: i = '{OP_MUL, SL_T1, SL_T8, SL_T1};
      7'd55: i = '{OP_MUL, SL_T10, SL_C, SL_T3};
      7'd56: i = '{OP_SUB, SL_T13, SL_T13, SL_T10};
      7'd57: i = '{OP_MUL, SL_T10, SL_T7, SL_T5};
      7'd58: i = '{OP_SUB, SL_T13, SL_T13, SL_T10};
      7'd59: i = '{OP_MUL, SL_T10, SL_T9, SL_T3};
      7'd60: i = '{OP_SUB, SL_T1, SL_T1, SL_T10};
      7'd61: i = '{OP_MUL, SL_T10, SL_C, SL_T5};
      7'd62: i = '{OP_SUB, SL_T1, SL_T1, SL_T10};
      7'd63: i = '{OP_MUL, SL_T13, SL_T11, SL_T13};
      7'd64: i = '{OP_MUL, SL_T1, SL_T12, SL_T1};
      7'd65: i = '{OP_SUB, SL_PFY, SL_T13, SL_T1};
      // commit new state
      7'd66: i = '{OP_ADD, SL_PX, SL_T2, SL_Z};
      7'd67: i = '{OP_ADD, SL_PY, SL_T3, SL_Z};
      7'd68: i = '{OP_ADD, SL_VX, SL_T4, SL_Z};
      7'd69: i = '{OP_ADD, SL_VY, SL_T5, SL_Z};
      default: i = '{OP_ADD, SL_PX, SL_PX, SL_Z};
    endcase
    return i;
  endfunction

endpackage

// ===== sv/pwsp_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsp_alu: shared saturating fixed point unit
// Add, subtract, halve and sign flip (or pass b through when odd) are computed at once and
// registered; shift-add multiply and restoring divide one bit per cycle, both rounded to nearest.
// ----------------------------------------------------------------------------
module pwsp_alu #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pwsp_pkg::alu_cmd_t       cmd_i,
  input  logic [DATA_WIDTH-1:0]    a_i,
  input  logic [DATA_WIDTH-1:0]    b_i,
  output logic [DATA_WIDTH-1:0]    res_o,
  output pwsp_pkg::alu_sts_t       sts_o
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = W + F;
  localparam int FW = 2 * W + 1;
  localparam int CW = $clog2(NW + 1);
  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  logic            busy_q, done_q, sat_q;
  logic [CW-1:0]   cnt_q;
  pwsp_pkg::op_e   op_q;
  logic            neg_q;
  logic [2*W-1:0]  acc_q, mc_q;
  logic [W-1:0]    mp_q, rem_q, ub_q, res_q;
  logic [NW-1:0]   quo_q, num_q;

  logic [W:0]      sa, sb, as_sum, half_t;
  logic            as_ovf;
  logic [W-1:0]    as_res, ma, mb, imm_res, mag, fin_res;
  logic            imm_sat, neg_in;
  logic [W:0]      r2, r2_sub;
  logic            ge, rnd;
  logic [FW-1:0]   mul_sum, fin, lim;
  logic            fin_ovf;

  always_comb begin
    sa     = {a_i[W-1], a_i};
    sb     = {b_i[W-1], b_i};
    as_sum = (cmd_i.op == pwsp_pkg::OP_ADD) ? sa + sb : sa - sb;
    as_ovf = as_sum[W] ^ as_sum[W-1];
    as_res = as_ovf ? (as_sum[W] ? MINW : MAXW) : as_sum[W-1:0];
    half_t = sa + (W+1)'(a_i[W-1]);
    ma     = a_i[W-1] ? (~a_i + 1'b1) : a_i;
    mb     = b_i[W-1] ? (~b_i + 1'b1) : b_i;
    neg_in = a_i[W-1] ^ b_i[W-1];

    imm_res = as_res;
    imm_sat = as_ovf;
    case (cmd_i.op)
      pwsp_pkg::OP_HALF: begin
        imm_res = half_t[W:1];
        imm_sat = 1'b0;
      end
      pwsp_pkg::OP_ALT: begin
        if (cmd_i.odd) begin
          imm_res = b_i;
          imm_sat = 1'b0;
        end
      end
      pwsp_pkg::OP_DIV: begin
        // divide by zero
        imm_res = (a_i == '0) ? '0 : (a_i[W-1] ? MINW : MAXW);
        imm_sat = (a_i != '0);
      end
      default: begin
        imm_res = as_res;
        imm_sat = as_ovf;
      end
    endcase

    // one restoring divide step
    r2     = {rem_q, num_q[NW-1]};
    r2_sub = r2 - {1'b0, ub_q};
    ge     = (r2 >= {1'b0, ub_q});

    // rounding and clamp at the end of a multiply or divide
    rnd     = ({rem_q, 1'b0} >= {1'b0, ub_q});
    mul_sum = {1'b0, acc_q} + (FW'(1) << (F - 1));
    fin     = (op_q == pwsp_pkg::OP_MUL) ? (mul_sum >> F) : (FW'(quo_q) + FW'(rnd));
    lim     = neg_q ? (FW'(1) << (W - 1)) : ((FW'(1) << (W - 1)) - FW'(1));
    fin_ovf = (fin > lim);
    mag     = fin_ovf ? lim[W-1:0] : fin[W-1:0];
    fin_res = neg_q ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        if (cmd_i.op == pwsp_pkg::OP_MUL) begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(W);
        end else if (cmd_i.op == pwsp_pkg::OP_DIV && b_i != '0) begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(NW);
        end else begin
          done_q <= 1'b1;
          sat_q  <= imm_sat;
        end
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          sat_q  <= fin_ovf;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= cmd_i.op;
      neg_q <= neg_in;
      acc_q <= '0;
      mc_q  <= {{W{1'b0}}, ma};
      mp_q  <= mb;
      rem_q <= '0;
      quo_q <= '0;
      num_q <= {ma, {F{1'b0}}};
      ub_q  <= mb;
      res_q <= imm_res;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        if (op_q == pwsp_pkg::OP_MUL) begin
          if (mp_q[0]) begin
            acc_q <= acc_q + mc_q;
          end
          mc_q <= mc_q << 1;
          mp_q <= mp_q >> 1;
        end else begin
          rem_q <= ge ? r2_sub[W-1:0] : r2[W-1:0];
          quo_q <= {quo_q[NW-2:0], ge};
          num_q <= num_q << 1;
        end
      end else begin
        res_q <= fin_res;
      end
    end
  end

  assign res_o = res_q;
  assign sts_o = '{done: done_q, sat: sat_q};

endmodule

// ===== sv/pendulum_walking_step_planner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pendulum_walking_step_planner: inverted pendulum foot placement planner
// One walking step per input word: advances the centre of mass, moves the
// nominal foot and computes the modified foot placement, saturating.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_stall_o  restart_i
//   out       source     out_valid_o/out_stall_i com_x/y_o, foot_x/y_o, saturated_o
//   cfg       sink       cfg_we_i               cfg_addr_i, cfg_wdata_i
//
// a step is a load sweep of the scratch slots, then fetch, start and wait
// for each of the 32 add-type ops, 32 multiplies and 6 divides (a zero
// divisor finishes at once, like an add), then the output states OUT_RD,
// OUT_COM and OUT_FOOT; every op runs on the single shared unit, and the
// sequencer returns to idle before it takes the next word;
// in_stall_o is high from acceptance until the sequencer is back in idle;
// a stalled result holds the sequencer before it reads out the next one
// state lives in a scratch memory that the first step after reset, or any step with restart_i, clears
//
module pendulum_walking_step_planner #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] com_x_o,
  output logic [31:0] com_y_o,
  output logic [31:0] foot_x_o,
  output logic [31:0] foot_y_o,
  output logic        saturated_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int W = DATA_WIDTH;
  localparam logic signed [63:0] MAXV = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] MINV = -MAXV - 64'sd1;
  localparam logic [W-1:0] ONE_V = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [6:0] PC_LAST = 7'(pwsp_pkg::NUM_INSTR - 1);

  // config registers
  logic [31:0] cfg_q [pwsp_pkg::NUM_CFG];

  // sequencer
  pwsp_pkg::st_e   state_q, state_d;
  logic [6:0]      pc_q;
  pwsp_pkg::slot_t ld_q;
  logic            clr_q, odd_q, sat_q;
  pwsp_pkg::instr_t instr;

  // scratch memory
  logic [W-1:0]    mem [pwsp_pkg::NUM_SLOTS];
  logic            we;
  pwsp_pkg::slot_t waddr, ra, rb;
  logic [W-1:0]    wdata, rd_a_q, rd_b_q;

  // shared unit
  pwsp_pkg::alu_cmd_t alu_cmd;
  pwsp_pkg::alu_sts_t alu_sts;
  logic [W-1:0]       alu_res;

  // load sweep helpers
  logic [2:0]   cfg_idx;
  logic [31:0]  cfg_raw;
  logic [W:0]   cfg_clamped;
  logic         ld_sat;

  // output register
  logic        out_valid_q, out_sat_q, out_go;
  logic [31:0] com_x_q, com_y_q, foot_x_q, foot_y_q;
  logic [32:0] o_a, o_b;

  // register value in the working range, {clamp, value}
  function automatic logic [W:0] cfg_val(input logic [31:0] r, input logic sgn);
    logic signed [63:0] sv;
    logic [W-1:0]       v;
    logic               s;
    sv = sgn ? {{32{r[31]}}, r} : {32'b0, r};
    s  = 1'b1;
    if (sv > MAXV) begin
      v = MAXV[W-1:0];
    end else if (sv < MINV) begin
      v = MINV[W-1:0];
    end else begin
      v = sv[W-1:0];
      s = 1'b0;
    end
    return {s, v};
  endfunction

  // working value clamped to the 32 bit port, {clamp, value}
  function automatic logic [32:0] to_out32(input logic [W-1:0] v);
    logic signed [63:0] sv;
    logic [31:0]        r;
    logic               s;
    sv = {{(64-W){v[W-1]}}, v};
    s  = 1'b1;
    if (sv > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (sv < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = sv[31:0];
      s = 1'b0;
    end
    return {s, r};
  endfunction

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pwsp_pkg::NUM_CFG; i++) begin
        cfg_q[i] <= pwsp_pkg::CFG_RESET[i];
      end
    end else if (cfg_we_i && (int'(cfg_addr_i) < pwsp_pkg::NUM_CFG)) begin
      cfg_q[cfg_addr_i] <= cfg_wdata_i & pwsp_pkg::CFG_MASK[cfg_addr_i];
    end
  end

  assign instr = pwsp_pkg::prog(pc_q);

  assign cfg_idx     = 3'(ld_q - pwsp_pkg::SL_C);
  assign cfg_raw     = (int'(cfg_idx) < pwsp_pkg::NUM_CFG) ? cfg_q[cfg_idx] : '0;
  assign cfg_clamped = (int'(cfg_idx) < pwsp_pkg::NUM_CFG) ?
                       cfg_val(cfg_raw, pwsp_pkg::CFG_SIGNED[cfg_idx]) : '0;

  assign o_a = to_out32(rd_a_q);
  assign o_b = to_out32(rd_b_q);

  // result register free or being emptied this cycle
  assign out_go = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pwsp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pwsp_pkg::ST_LOAD;
      end
      pwsp_pkg::ST_LOAD: begin
        if (ld_q == pwsp_pkg::SL_PFY) state_d = pwsp_pkg::ST_FETCH;
      end
      pwsp_pkg::ST_FETCH:  state_d = pwsp_pkg::ST_START;
      pwsp_pkg::ST_START:  state_d = pwsp_pkg::ST_WAIT;
      pwsp_pkg::ST_WAIT: begin
        if (alu_sts.done) begin
          state_d = (pc_q == PC_LAST) ? pwsp_pkg::ST_OUT_RD : pwsp_pkg::ST_FETCH;
        end
      end
      // wait here until the previous word has left the output register
      pwsp_pkg::ST_OUT_RD: begin
        if (out_go) state_d = pwsp_pkg::ST_OUT_COM;
      end
      pwsp_pkg::ST_OUT_COM: state_d = pwsp_pkg::ST_OUT_FOOT;
      pwsp_pkg::ST_OUT_FOOT: begin
        if (out_go) state_d = pwsp_pkg::ST_IDLE;
      end
      default: state_d = pwsp_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    we      = 1'b0;
    waddr   = instr.dst;
    wdata   = alu_res;
    ra      = instr.a;
    rb      = instr.b;
    ld_sat  = 1'b0;
    alu_cmd = '{start: 1'b0, op: instr.op, odd: odd_q};
    case (state_q)
      pwsp_pkg::ST_LOAD: begin
        // constants, clamped registers, then state clear when needed
        waddr = ld_q;
        if (ld_q == pwsp_pkg::SL_Z) begin
          we    = 1'b1;
          wdata = '0;
        end else if (ld_q == pwsp_pkg::SL_ONE) begin
          we    = 1'b1;
          wdata = ONE_V;
        end else if (ld_q <= pwsp_pkg::SL_WB) begin
          we     = 1'b1;
          wdata  = cfg_clamped[W-1:0];
          ld_sat = cfg_clamped[W];
        end else begin
          we    = clr_q;
          wdata = '0;
        end
      end
      pwsp_pkg::ST_START: alu_cmd.start = 1'b1;
      pwsp_pkg::ST_WAIT:  we = alu_sts.done;
      pwsp_pkg::ST_OUT_RD: begin
        ra = pwsp_pkg::SL_PX;
        rb = pwsp_pkg::SL_PY;
      end
      pwsp_pkg::ST_OUT_COM, pwsp_pkg::ST_OUT_FOOT: begin
        ra = pwsp_pkg::SL_PFX;
        rb = pwsp_pkg::SL_PFY;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // scratch memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  pwsp_alu #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (alu_cmd),
    .a_i   (rd_a_q),
    .b_i   (rd_b_q),
    .res_o (alu_res),
    .sts_o (alu_sts)
  );

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pwsp_pkg::ST_IDLE;
      pc_q        <= '0;
      ld_q        <= '0;
      clr_q       <= 1'b1;
      odd_q       <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        pwsp_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            clr_q <= clr_q | restart_i;
            if (restart_i) odd_q <= 1'b0;
            sat_q <= 1'b0;
            ld_q  <= '0;
            pc_q  <= '0;
          end
        end
        pwsp_pkg::ST_LOAD: begin
          sat_q <= sat_q | ld_sat;
          ld_q  <= ld_q + 1'b1;
          if (ld_q == pwsp_pkg::SL_PFY) clr_q <= 1'b0;
        end
        pwsp_pkg::ST_WAIT: begin
          if (alu_sts.done) begin
            sat_q <= sat_q | alu_sts.sat;
            if (pc_q != PC_LAST) pc_q <= pc_q + 1'b1;
          end
        end
        pwsp_pkg::ST_OUT_COM: begin
          sat_q <= sat_q | o_a[32] | o_b[32];
        end
        pwsp_pkg::ST_OUT_FOOT: begin
          if (out_go) begin
            out_valid_q <= 1'b1;
            odd_q       <= ~odd_q;
          end
        end
        default: begin
          pc_q <= pc_q;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == pwsp_pkg::ST_OUT_COM) begin
      com_x_q <= o_a[31:0];
      com_y_q <= o_b[31:0];
    end
    if (state_q == pwsp_pkg::ST_OUT_FOOT && out_go) begin
      foot_x_q  <= o_a[31:0];
      foot_y_q  <= o_b[31:0];
      out_sat_q <= sat_q | o_a[32] | o_b[32];
    end
  end

  assign in_stall_o  = (state_q != pwsp_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign com_x_o     = com_x_q;
  assign com_y_o     = com_y_q;
  assign foot_x_o    = foot_x_q;
  assign foot_y_o    = foot_y_q;
  assign saturated_o = out_sat_q;

`ifndef SYNTH
  // the shared unit only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_sts.done |-> (state_q == pwsp_pkg::ST_WAIT))
    else $error("alu finished outside wait state");

  // program counter never runs past the last instruction
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_LAST)
    else $error("program counter out of range");

  // a new result word appears only from the final output state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == pwsp_pkg::ST_OUT_FOOT))
    else $error("result word raised outside output state");
`endif

endmodule
